/* rtl/sird_pkg.sv */
// ----------------------------------------------------------------------------
// sird_pkg
// Shared constants and types for the signed integer to radix digits block.
// ----------------------------------------------------------------------------
package sird_pkg;

  // default parameter values
  localparam int unsigned DEF_MAX_RADIX  = 16;
  localparam int unsigned DEF_VALUE_BITS = 32;

  // fixed field widths
  localparam int unsigned RADIX_W     = 5;   // radix_len register width
  localparam int unsigned ALPHA_W     = 64;  // one alphabet half
  localparam int unsigned ALPHA_SIZE  = 16;  // entries in the full alphabet
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned DIGIT_W     = 4;   // one stacked digit
  localparam int unsigned COUNT_W     = 6;   // character count
  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned STACK_AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CFG_IDX_W   = 2;

  // characters that may not appear among the used alphabet entries
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  // register reset values
  localparam logic [RADIX_W-1:0] RADIX_LEN_RST  = 5'd10;
  localparam logic [ALPHA_W-1:0] ALPHA_LOW_RST  = 64'h3736353433323130;
  localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RST = 64'h0000000000003938;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX_LEN  = 2'd0,
    CFG_ALPHA_LOW  = 2'd1,
    CFG_ALPHA_HIGH = 2'd2
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_WAIT  = 6'b000100,
    S_SIGN  = 6'b001000,
    S_DIGIT = 6'b010000,
    S_ERR   = 6'b100000
  } seq_state_t;

endpackage

/* rtl/sird_in_if.sv */
// ----------------------------------------------------------------------------
// sird_in_if
// Request channel: one signed value per request.
// ----------------------------------------------------------------------------
interface sird_in_if import sird_pkg::*; #(
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* rtl/sird_out_if.sv */
// ----------------------------------------------------------------------------
// sird_out_if
// Result channel: one character per transfer.
// ----------------------------------------------------------------------------
interface sird_out_if import sird_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  out_char;
  logic               last;
  logic               error;
  logic [COUNT_W-1:0] char_count;

  modport source (output valid, output out_char, output last, output error,
                  output char_count, input ready);
  modport sink   (input valid, input out_char, input last, input error,
                  input char_count, output ready);
endinterface

/* rtl/sird_check.sv */
// ----------------------------------------------------------------------------
// sird_check
// Alphabet and radix validation against the current configuration.
// ----------------------------------------------------------------------------
module sird_check import sird_pkg::*; #(
  parameter int unsigned MAX_RADIX = DEF_MAX_RADIX
) (
  input  logic [RADIX_W-1:0]           radix_len,
  input  logic [CHAR_W*ALPHA_SIZE-1:0] alphabet,
  output logic                         bad
);

  always_comb begin
    bad = (radix_len < RADIX_W'(2)) || (radix_len > RADIX_W'(MAX_RADIX)) ||
          (radix_len > RADIX_W'(ALPHA_SIZE));
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      if (RADIX_W'(i) < radix_len) begin
        if (alphabet[i*CHAR_W +: CHAR_W] == CHAR_MINUS ||
            alphabet[i*CHAR_W +: CHAR_W] == CHAR_PLUS ||
            alphabet[i*CHAR_W +: CHAR_W] == CHAR_NUL) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < ALPHA_SIZE; j++) begin
          // duplicate among used entries
          if (RADIX_W'(j) < radix_len &&
              alphabet[j*CHAR_W +: CHAR_W] == alphabet[i*CHAR_W +: CHAR_W]) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

endmodule

/* rtl/sird_div.sv */
// ----------------------------------------------------------------------------
// sird_div
// Restoring divider by a small radix, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sird_div import sird_pkg::*; #(
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]    divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [RADIX_W-1:0]    remainder
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [RADIX_W-1:0]    rem_r, rem_nxt;
  logic [RADIX_W:0]      trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, quo_r[VALUE_BITS-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = RADIX_W'(trial - {1'b0, divisor});
        quo_nxt = {quo_r[VALUE_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[RADIX_W-1:0];
        quo_nxt = {quo_r[VALUE_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(VALUE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* rtl/signed_int_to_radix_digits.sv */
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits
// Writes a signed integer as text in a configurable radix and alphabet.
// ----------------------------------------------------------------------------
// usage
//   in_req  : one signed value per request (valid/ready)
//   out_res : one character per transfer, last set on the final one, which
//             also carries the total character count
//   cfg_*   : write port for radix_len, alphabet_low, alphabet_high; write
//             only while the block is idle
// a negative value gives '-' first, then digits most significant first;
// the most negative value is exact. a bad radix or alphabet gives a single
// result with error set and no character
// timing
//   in_req.ready is high only when the sequencer is idle
//   each digit is made on the shared bit-serial divider: start, one
//   quotient bit per cycle, then handoff; then one character goes out per
//   cycle while the receiver is not stalling
// a stalled receiver holds the output register and the sequencer waits;
// after the last character is loaded the next value is accepted at once
// reset returns radix 10 with alphabet "0123456789" and an empty pipeline
// ----------------------------------------------------------------------------
module signed_int_to_radix_digits import sird_pkg::*; #(
  parameter int unsigned MAX_RADIX  = DEF_MAX_RADIX,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [ALPHA_W-1:0]   cfg_wdata,
  sird_in_if.sink              in_req,
  sird_out_if.source           out_res
);

  // configuration registers
  logic [RADIX_W-1:0] radix_len_r;
  logic [ALPHA_W-1:0] alpha_low_r;
  logic [ALPHA_W-1:0] alpha_high_r;

  // sequencer state
  seq_state_t            state_r, state_nxt;
  logic                  neg_r, neg_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;   // digits stacked so far
  logic [COUNT_W-1:0]    k_r, k_nxt;           // digits still to emit
  logic [DIGIT_W-1:0]    stack_r [STACK_DEPTH];

  // output register
  logic               ovalid_r, ovalid_nxt;
  logic [CHAR_W-1:0]  ochar_r, ochar_nxt;
  logic               olast_r, olast_nxt;
  logic               oerr_r, oerr_nxt;
  logic [COUNT_W-1:0] ocnt_r, ocnt_nxt;

  logic                         bad;
  logic                         accept;
  logic                         out_free;
  logic                         div_start;
  logic                         div_done;
  logic [VALUE_BITS-1:0]        div_quo;
  logic [RADIX_W-1:0]           div_rem;
  logic [COUNT_W-1:0]           total;
  logic [COUNT_W-1:0]           count_inc;
  logic [COUNT_W-1:0]           k_dec;
  logic [DIGIT_W-1:0]           digit;
  logic [CHAR_W*ALPHA_SIZE-1:0] alphabet;

  // full sixteen-entry alphabet, entry 0 in the low byte
  assign alphabet = {alpha_high_r, alpha_low_r};

  sird_check #(
    .MAX_RADIX (MAX_RADIX)
  ) u_check (
    .radix_len (radix_len_r),
    .alphabet  (alphabet),
    .bad       (bad)
  );

  sird_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mag_r),
    .divisor   (radix_len_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign accept    = in_req.valid && in_req.ready;
  assign out_free  = !ovalid_r || out_res.ready;
  assign total     = count_r + COUNT_W'(neg_r);
  assign count_inc = count_r + COUNT_W'(1);
  assign k_dec     = k_r - COUNT_W'(1);
  assign digit     = stack_r[k_dec[STACK_AW-1:0]];

  always_comb begin
    state_nxt  = state_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    ovalid_nxt = ovalid_r && !out_res.ready;
    ochar_nxt  = ochar_r;
    olast_nxt  = olast_r;
    oerr_nxt   = oerr_r;
    ocnt_nxt   = ocnt_r;
    div_start  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          neg_nxt   = in_req.value[VALUE_BITS-1];
          // magnitude as unsigned, so the most negative value is exact
          mag_nxt   = in_req.value[VALUE_BITS-1] ? (VALUE_BITS'(0) - in_req.value)
                                                 : in_req.value;
          count_nxt = '0;
          state_nxt = bad ? S_ERR : S_START;
        end
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          mag_nxt   = div_quo;
          count_nxt = count_inc;
          if (div_quo != '0 && count_inc < COUNT_W'(STACK_DEPTH)) begin
            state_nxt = S_START;
          end else begin
            k_nxt     = count_inc;
            state_nxt = neg_r ? S_SIGN : S_DIGIT;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = CHAR_MINUS;
          olast_nxt  = (total == COUNT_W'(1));
          oerr_nxt   = 1'b0;
          ocnt_nxt   = '0;
          state_nxt  = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = alphabet[digit*CHAR_W +: CHAR_W];
          olast_nxt  = (k_r == COUNT_W'(1));
          oerr_nxt   = 1'b0;
          ocnt_nxt   = (k_r == COUNT_W'(1)) ? total : '0;
          k_nxt      = k_dec;
          if (k_r == COUNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ERR: begin
        // single error result, no characters
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = CHAR_NUL;
          olast_nxt  = 1'b1;
          oerr_nxt   = 1'b1;
          ocnt_nxt   = '0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ovalid_r     <= 1'b0;
      neg_r        <= 1'b0;
      mag_r        <= '0;
      count_r      <= '0;
      k_r          <= '0;
      radix_len_r  <= RADIX_LEN_RST;
      alpha_low_r  <= ALPHA_LOW_RST;
      alpha_high_r <= ALPHA_HIGH_RST;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      neg_r    <= neg_nxt;
      mag_r    <= mag_nxt;
      count_r  <= count_nxt;
      k_r      <= k_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_RADIX_LEN:  radix_len_r  <= cfg_wdata[RADIX_W-1:0];
          CFG_ALPHA_LOW:  alpha_low_r  <= cfg_wdata;
          CFG_ALPHA_HIGH: alpha_high_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  // digit stack, written as each remainder comes out of the divider
  always_ff @(posedge clk) begin
    if (state_r == S_WAIT && div_done) begin
      stack_r[count_r[STACK_AW-1:0]] <= div_rem[DIGIT_W-1:0];
    end
  end

  assign in_req.ready       = (state_r == S_IDLE);
  assign out_res.valid      = ovalid_r;
  assign out_res.out_char   = ochar_r;
  assign out_res.last       = olast_r;
  assign out_res.error      = oerr_r;
  assign out_res.char_count = ocnt_r;

endmodule

/* tb/signed_int_to_radix_digits_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits_tb
// Drives signed values through the radix text writer under several radixes
// and alphabets, good and bad, and checks every character, last flag, error
// flag and count against a cycle-free model of the expected text.
// ----------------------------------------------------------------------------
module signed_int_to_radix_digits_tb;
  import sird_pkg::*;

  localparam int unsigned MAX_RADIX    = DEF_MAX_RADIX;
  localparam int unsigned VALUE_BITS   = DEF_VALUE_BITS;
  localparam int          HALF_PERIOD  = 1;
  localparam int          RESET_CYCLES = 6;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          TAIL_CYCLES   = 1200;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          PHASE_ITEMS   = 130;
  localparam int          SETTING_RUN   = 25;
  // limit on the whole run, in ns
  localparam longint      LIMIT_NS      = 64'd10_000_000;

  // ways to spoil an alphabet
  typedef enum int {
    FAULT_NONE,
    FAULT_MINUS,
    FAULT_PLUS,
    FAULT_NUL,
    FAULT_DUP
  } fault_t;

  // one expected character of the text
  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic               err;
    logic [COUNT_W-1:0] count;
  } text_char_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  cfg_idx_t             cfg_idx;
  logic [ALPHA_W-1:0]   cfg_wdata;

  sird_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  sird_out_if                           out_ch ();

  signed_int_to_radix_digits #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_BITS (VALUE_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_ch),
    .out_res   (out_ch)
  );

  // our copy of the registers, updated with every write
  logic [RADIX_W-1:0] radix_shadow;
  logic [ALPHA_W-1:0] alpha_low_shadow;
  logic [ALPHA_W-1:0] alpha_high_shadow;

  // characters still owed by the block, oldest first
  text_char_t expected_text[$];

  int  fail_count;
  int  values_sent;
  int  chars_checked;
  int  rejects_checked;
  int  settings_loaded;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_req;

  // --------------------------------------------------------------------------
  // clock and run limit
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  initial begin
    #(LIMIT_NS);
    $display("timeout: %0d characters still owed", expected_text.size());
    $display("signed_int_to_radix_digits_tb failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // model of the text for one value
  // --------------------------------------------------------------------------

  // alphabet entry at a digit position
  function automatic logic [CHAR_W-1:0] alpha_char(input int idx);
    if (idx < 8) begin
      return alpha_low_shadow[idx*8 +: 8];
    end
    return alpha_high_shadow[(idx-8)*8 +: 8];
  endfunction

  // radix in range and used entries free of sign, nul and repeats
  function automatic bit alphabet_usable();
    logic [CHAR_W-1:0] c;
    if (radix_shadow < 2 || radix_shadow > MAX_RADIX) begin
      return 1'b0;
    end
    for (int i = 0; i < radix_shadow; i++) begin
      c = alpha_char(i);
      if (c == CHAR_MINUS || c == CHAR_PLUS || c == CHAR_NUL) begin
        return 1'b0;
      end
      for (int j = i + 1; j < radix_shadow; j++) begin
        if (alpha_char(j) == c) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  // push the characters that one accepted value must produce
  function automatic void predict_text(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0] mag;
    logic [DIGIT_W-1:0]    digits[STACK_DEPTH];
    logic [COUNT_W-1:0]    total;
    text_char_t            tc;
    bit                    neg;
    int                    n;
    if (!alphabet_usable()) begin
      tc = '{ch: CHAR_NUL, last: 1'b1, err: 1'b1, count: '0};
      expected_text.push_back(tc);
      return;
    end
    neg = v[VALUE_BITS-1];
    // unsigned negate keeps the most negative value exact
    mag = neg ? (~v + 1'b1) : v;
    n = 0;
    do begin
      digits[n] = DIGIT_W'(mag % radix_shadow);
      mag = mag / radix_shadow;
      n++;
    end while (mag != 0 && n < STACK_DEPTH);
    total = COUNT_W'(n + (neg ? 1 : 0));
    if (neg) begin
      tc = '{ch: CHAR_MINUS, last: (total == 1), err: 1'b0, count: '0};
      expected_text.push_back(tc);
    end
    for (int k = n; k > 0; k--) begin
      tc = '{ch: alpha_char(digits[k-1]), last: (k == 1), err: 1'b0,
             count: (k == 1) ? total : '0};
      expected_text.push_back(tc);
    end
  endfunction

  // --------------------------------------------------------------------------
  // receiver: random stalls, or one long hold-off when asked
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checker, sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    text_char_t exp_c;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_text.size() == 0) begin
        $error("unexpected character 0x%02h with no request pending",
               out_ch.out_char);
        fail_count++;
      end else begin
        exp_c = expected_text.pop_front();
        chars_checked++;
        if (exp_c.err) begin
          rejects_checked++;
        end
        if (out_ch.out_char !== exp_c.ch) begin
          $error("out_char: expected 0x%02h, got 0x%02h", exp_c.ch, out_ch.out_char);
          fail_count++;
        end
        if (out_ch.last !== exp_c.last) begin
          $error("last: expected %0b, got %0b", exp_c.last, out_ch.last);
          fail_count++;
        end
        if (out_ch.error !== exp_c.err) begin
          $error("error: expected %0b, got %0b", exp_c.err, out_ch.error);
          fail_count++;
        end
        if (out_ch.char_count !== exp_c.count) begin
          $error("char_count: expected %0d, got %0d", exp_c.count, out_ch.char_count);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // shared driving tasks
  // --------------------------------------------------------------------------

  // offer one request and record its text once accepted
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predict_text(v);
    values_sent++;
  endtask

  // drop valid, let every owed character arrive, then a short pause
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [ALPHA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // write all three registers while the block is idle
  task automatic apply_setting(input int radix, input logic [ALPHA_W-1:0] lo,
                               input logic [ALPHA_W-1:0] hi);
    logic [ALPHA_W-1:0] radix_word;
    wait_idle();
    // junk above the radix field must be ignored
    radix_word = {$urandom, $urandom};
    radix_word[RADIX_W-1:0] = RADIX_W'(radix);
    write_reg(CFG_RADIX_LEN, radix_word);
    write_reg(CFG_ALPHA_LOW, lo);
    write_reg(CFG_ALPHA_HIGH, hi);
    radix_shadow      = RADIX_W'(radix);
    alpha_low_shadow  = lo;
    alpha_high_shadow = hi;
    settings_loaded++;
  endtask

  // random distinct alphabet, optionally spoiled, unused tail optionally junk
  task automatic load_setting(input int radix, input fault_t fault,
                              input bit junk_tail);
    logic [CHAR_W-1:0]  chars[ALPHA_SIZE];
    logic [255:0]       taken;
    logic [ALPHA_W-1:0] lo;
    logic [ALPHA_W-1:0] hi;
    int                 used;
    int                 pos;
    int                 other;
    taken = '0;
    taken[CHAR_NUL]   = 1'b1;
    taken[CHAR_MINUS] = 1'b1;
    taken[CHAR_PLUS]  = 1'b1;
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      chars[i] = CHAR_W'($urandom_range(255));
      while (taken[chars[i]]) chars[i] = CHAR_W'($urandom_range(255));
      taken[chars[i]] = 1'b1;
    end
    used = (radix > ALPHA_SIZE) ? ALPHA_SIZE : radix;
    if (junk_tail) begin
      // entries past the radix may hold anything
      for (int i = used; i < ALPHA_SIZE; i++) begin
        chars[i] = (i == used) ? CHAR_MINUS : (i == used + 1) ? CHAR_PLUS :
                   (i == used + 2) ? chars[0] : CHAR_NUL;
      end
    end
    if (used >= 2 && fault != FAULT_NONE) begin
      pos = $urandom_range(used - 1);
      case (fault)
        FAULT_MINUS: chars[pos] = CHAR_MINUS;
        FAULT_PLUS:  chars[pos] = CHAR_PLUS;
        FAULT_NUL:   chars[pos] = CHAR_NUL;
        default: begin
          other = $urandom_range(used - 1);
          if (other == pos) begin
            other = (pos + 1) % used;
          end
          chars[other] = chars[pos];
        end
      endcase
    end
    for (int i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = chars[i];
      hi[i*8 +: 8] = chars[i+8];
    end
    apply_setting(radix, lo, hi);
  endtask

  // mostly full-width values, with small ones and the extremes mixed in
  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(9))
      0: return VALUE_BITS'($urandom_range(40));
      1: return -VALUE_BITS'($urandom_range(1, 40));
      2: begin
        case ($urandom_range(3))
          0: return {1'b1, {(VALUE_BITS-1){1'b0}}};
          1: return {1'b0, {(VALUE_BITS-1){1'b1}}};
          2: return '1;
          default: return '0;
        endcase
      end
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // decimal text straight out of reset, before any register write
  task automatic test_reset_decimal();
    send_value('0);
    send_value(VALUE_BITS'(1));
    send_value('1);
    send_value({1'b0, {(VALUE_BITS-1){1'b1}}});
    send_value({1'b1, {(VALUE_BITS-1){1'b0}}});
    send_value(VALUE_BITS'(-10));
  endtask

  // each way the radix or alphabet can be refused, plus an ignored junk tail
  task automatic test_bad_alphabet();
    load_setting(0, FAULT_NONE, 1'b0);
    send_value(VALUE_BITS'(7));
    load_setting(1, FAULT_NONE, 1'b0);
    send_value(VALUE_BITS'(-7));
    load_setting(MAX_RADIX + 1, FAULT_NONE, 1'b0);
    send_value('0);
    load_setting((1 << RADIX_W) - 1, FAULT_NONE, 1'b0);
    send_value('1);
    load_setting(10, FAULT_MINUS, 1'b0);
    send_value(VALUE_BITS'(123));
    load_setting(10, FAULT_PLUS, 1'b0);
    send_value(VALUE_BITS'(123));
    load_setting(10, FAULT_NUL, 1'b0);
    send_value(VALUE_BITS'(123));
    load_setting(10, FAULT_DUP, 1'b0);
    send_value(VALUE_BITS'(123));
    // sign, plus, nul and a repeat past the radix are fine
    load_setting(3, FAULT_NONE, 1'b1);
    send_value(VALUE_BITS'(-100));
  endtask

  // radix 2 gives the longest text: sign and 32 digits for the most negative
  task automatic test_binary_extremes();
    apply_setting(2, 64'h0000_0000_0000_3130, '1);
    send_value({1'b1, {(VALUE_BITS-1){1'b0}}});
    send_value('1);
    send_value({1'b0, {(VALUE_BITS-1){1'b1}}});
  endtask

  // full sixteen-entry alphabet, one entry with the top bit set
  task automatic test_full_radix();
    apply_setting(MAX_RADIX, 64'h3736_3534_3332_3130, 64'hFF65_6463_6261_3938);
    send_value('0);
    send_value('1);
    send_value({1'b0, {(VALUE_BITS-1){1'b1}}});
    send_value(VALUE_BITS'(32'hFEDC_BA98));
  endtask

  // receiver stops for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    int saved_send;
    saved_send = send_idle_pct;
    send_idle_pct = 0;
    load_setting(10, FAULT_NONE, 1'b0);
    hold_req = 1'b1;
    repeat (8) send_value(pick_value());
    send_idle_pct = saved_send;
    wait_idle();
  endtask

  // long random run with fresh settings every so often
  task automatic test_random_traffic(input int items, input int send_pct,
                                     input int recv_pct);
    fault_t fault;
    int     radix;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < items; i++) begin
      if (i % SETTING_RUN == 0) begin
        radix = $urandom_range(2, MAX_RADIX);
        fault = FAULT_NONE;
        if ($urandom_range(5) == 0) begin
          // roughly one setting in six is refused
          if ($urandom_range(4) == 0) begin
            radix = $urandom_range(1) ? $urandom_range(1)
                                      : $urandom_range(MAX_RADIX + 1, (1 << RADIX_W) - 1);
          end else begin
            fault = fault_t'($urandom_range(FAULT_MINUS, FAULT_DUP));
          end
        end
        load_setting(radix, fault, ($urandom_range(3) == 0));
      end
      send_value(pick_value());
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_RADIX_LEN;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    hold_req     = 1'b0;
    fail_count      = 0;
    values_sent     = 0;
    chars_checked   = 0;
    rejects_checked = 0;
    settings_loaded = 0;
    send_idle_pct   = 19;
    recv_idle_pct   = 78;
    radix_shadow      = RADIX_LEN_RST;
    alpha_low_shadow  = ALPHA_LOW_RST;
    alpha_high_shadow = ALPHA_HIGH_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_decimal();
    test_bad_alphabet();
    test_binary_extremes();
    test_full_radix();
    test_output_backpressure();
    test_random_traffic(PHASE_ITEMS, 19, 78);
    test_random_traffic(PHASE_ITEMS, 78, 19);
    test_random_traffic(PHASE_ITEMS, 0, 0);

    // the last text may still be on its way, allow a full binary value
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d values under %0d register settings", values_sent,
             settings_loaded);
    $display("checked %0d characters, %0d of them refused-alphabet results",
             chars_checked, rejects_checked);
    if (fail_count == 0 && expected_text.size() == 0) begin
      $display("signed_int_to_radix_digits_tb passed");
    end else begin
      $display("%0d mismatches, %0d characters never arrived", fail_count,
               expected_text.size());
      $display("signed_int_to_radix_digits_tb failed");
    end
    $finish;
  end

endmodule
